// ===== rtl/core/sacache_pkg.sv =====
// Package for the set-associative cache: item payload types, config struct,
// controller/datapath command and status structs. No dependencies.
package sacache_pkg;

  localparam int ADDR_BITS = 48;

  typedef struct packed {
    logic                 is_write;
    logic [ADDR_BITS-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] read_total;
    logic [31:0] write_total;
  } out_item_t;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
    logic [3:0] ways_in_use;
    logic       use_lru;
  } cfg_t;

  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;
  localparam logic [1:0] REG_USE_LRU     = 2'd3;

  localparam int CFG_W = 4;

  typedef struct packed {
    logic load;     // capture input item, start set read
    logic update;   // on a miss or with LRU write back chosen way, update counters, form result
  } cmd_t;

  typedef struct packed {
    logic ready;    // valid-bit clearing pass after reset is done
  } status_t;

endpackage

// ===== rtl/core/set_assoc_cache_fifo_lru.sv =====
// Top level of the set-associative cache (FIFO/LRU): config registers,
// controller and datapath. Depends on sacache_pkg, sacache_ctrl, sacache_dp.
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall  | in_item  (is_write, address)
//  out     | out       | out_valid/out_stall| out_item (flags, totals)
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// An item is taken with a set read from the way memories, then compare, victim
// choice and, on a miss or with LRU, write-back of one way; no new item is taken
// before the last result leaves. Synchronous reset clears counters, sets config
// to defaults; the valid bits are then cleared one set per cycle, all MAX_SETS
// sets, with input stalled. A held result stalls the input until it is taken.
module set_assoc_cache_fifo_lru #(
  parameter int MAX_SETS  = 256,
  parameter int MAX_WAYS  = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  sacache_pkg::in_item_t   in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output sacache_pkg::out_item_t  out_item,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [3:0]              cfg_data
);
  import sacache_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{offset_bits: 4'd6, index_bits: 4'd4, ways_in_use: 4'd1, use_lru: 1'b0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_BITS: cfg.offset_bits <= cfg_data;
        REG_INDEX_BITS:  cfg.index_bits  <= cfg_data;
        REG_WAYS:        cfg.ways_in_use <= cfg_data;
        REG_USE_LRU:     cfg.use_lru     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sacache_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .status
  );

  sacache_dp #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_dp (
    .clk, .rst, .cfg, .in_item, .cmd, .status, .out_item
  );
endmodule

// ===== rtl/core/sacache_ctrl.sv =====
// Controller state machine for the set-associative cache.
// Depends on sacache_pkg.
module sacache_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sacache_pkg::cmd_t    cmd,
  input  sacache_pkg::status_t status
);
  import sacache_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_HOLD} state_t;
  state_t state;

  // A new item is taken in the cycle the held result leaves.
  assign in_stall   = !status.ready ||
                      !(state == S_IDLE || (state == S_HOLD && !out_stall));
  assign cmd.load   = in_valid && !in_stall;
  assign cmd.update = (state == S_LOOK) && status.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (cmd.load) state <= S_LOOK;
        S_LOOK: begin
          state     <= S_HOLD;
          out_valid <= 1'b1;
        end
        S_HOLD: if (!out_stall) begin
          out_valid <= 1'b0;
          state     <= cmd.load ? S_LOOK : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/sacache_dp.sv =====
// Datapath for the set-associative cache: line memories, valid bits, tag
// compare, victim choice, stamp and counters. Depends on sacache_pkg.
module sacache_dp #(
  parameter int MAX_SETS  = 256,
  parameter int MAX_WAYS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sacache_pkg::cfg_t      cfg,
  input  sacache_pkg::in_item_t  in_item,
  input  sacache_pkg::cmd_t      cmd,
  output sacache_pkg::status_t   status,
  output sacache_pkg::out_item_t out_item
);
  import sacache_pkg::*;

  localparam int SB = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WB = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int MAXIB = $clog2(MAX_SETS + 1) - 1;

  logic [ADDR_BITS-1:0] tag_mem   [MAX_WAYS][MAX_SETS];
  logic [63:0]          stamp_mem [MAX_WAYS][MAX_SETS];
  logic [MAX_WAYS-1:0]  valid_bits [MAX_SETS];

  logic [ADDR_BITS-1:0] rd_tag   [MAX_WAYS];
  logic [63:0]          rd_stamp [MAX_WAYS];
  logic [MAX_WAYS-1:0]  rd_valid;

  logic [ADDR_BITS-1:0] cur_tag;
  logic [SB-1:0]        cur_set;
  logic                 cur_wr;
  logic [63:0]          stamp_counter;
  logic [31:0]          hit_count, miss_count, read_count, write_count;

  logic                 clearing;
  logic [SB-1:0]        clr_idx;

  logic [ADDR_BITS-1:0] addr;
  logic [3:0]           ib;
  logic [4:0]           sh;
  logic [ADDR_BITS-1:0] set_full;
  logic [ADDR_BITS-1:0] tag_calc;
  logic [SB-1:0]        set_calc;

  assign addr = in_item.address[ADDR_BITS-1:0];
  assign ib = (32'(cfg.index_bits) > MAXIB) ? 4'(MAXIB) : cfg.index_bits;
  assign sh = 5'(cfg.offset_bits) + 5'(ib);
  assign set_full = (addr >> cfg.offset_bits) & ((ADDR_BITS'(1) << ib) - ADDR_BITS'(1));
  assign set_calc = SB'(set_full);
  assign tag_calc = (32'(sh) >= ADDR_BITS) ? '0 : (addr >> sh);

  assign status.ready = !clearing;

  // Lookup
  logic [4:0]          ways;
  logic [MAX_WAYS-1:0] in_use, hits, frees;
  logic                hit;
  logic [WB-1:0]       hit_way, free_way, old_way, tgt;
  logic                any_free;

  assign ways = (cfg.ways_in_use == 4'd0) ? 5'd1 :
                (32'(cfg.ways_in_use) > MAX_WAYS) ? 5'(MAX_WAYS) : 5'(cfg.ways_in_use);

  always_comb begin
    logic [63:0] best;
    hit = 1'b0; hit_way = '0; any_free = 1'b0; free_way = '0; old_way = '0;
    best = rd_stamp[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = 32'(w) < 32'(ways);
      hits[w]   = in_use[w] && rd_valid[w] && rd_tag[w] == cur_tag;
      frees[w]  = in_use[w] && !rd_valid[w];
    end
    for (int w = MAX_WAYS-1; w >= 0; w--) begin
      if (hits[w]) begin hit = 1'b1; hit_way = WB'(w); end
      if (frees[w]) begin any_free = 1'b1; free_way = WB'(w); end
    end
    for (int w = 1; w < MAX_WAYS; w++)
      if (in_use[w] && best > rd_stamp[w]) begin best = rd_stamp[w]; old_way = WB'(w); end
    tgt = hit ? hit_way : (any_free ? free_way : old_way);
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  logic do_write;
  assign do_write = cmd.update && (!hit || cfg.use_lru);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_tag  <= tag_calc;
      cur_set  <= set_calc;
      cur_wr   <= in_item.is_write;
      rd_valid <= valid_bits[set_calc];
      for (int w = 0; w < MAX_WAYS; w++) begin
        rd_tag[w]   <= tag_mem[w][set_calc];
        rd_stamp[w] <= stamp_mem[w][set_calc];
      end
    end
    for (int w = 0; w < MAX_WAYS; w++)
      if (do_write && tgt == WB'(w)) begin
        stamp_mem[w][cur_set] <= stamp_counter;
        if (!hit) tag_mem[w][cur_set] <= cur_tag;
      end
    if (clearing) valid_bits[clr_idx] <= '0;
    else if (cmd.update && !hit)
      valid_bits[cur_set] <= rd_valid | (MAX_WAYS'(1) << tgt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_idx       <= '0;
      stamp_counter <= '0;
      hit_count     <= '0;
      miss_count    <= '0;
      read_count    <= '0;
      write_count   <= '0;
      out_item      <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + SB'(1);
        if (clr_idx == SB'(MAX_SETS - 1)) clearing <= 1'b0;
      end
      if (cmd.update) begin
        if (do_write) stamp_counter <= stamp_counter + 64'd1;
        out_item.hit         <= hit;
        out_item.mem_read    <= !hit;
        out_item.mem_write   <= cur_wr;
        out_item.hit_total   <= hit ? sat_inc(hit_count) : hit_count;
        out_item.miss_total  <= hit ? miss_count : sat_inc(miss_count);
        out_item.read_total  <= hit ? read_count : sat_inc(read_count);
        out_item.write_total <= cur_wr ? sat_inc(write_count) : write_count;
        if (hit) hit_count <= sat_inc(hit_count);
        else begin
          miss_count <= sat_inc(miss_count);
          read_count <= sat_inc(read_count);
        end
        if (cur_wr) write_count <= sat_inc(write_count);
      end
    end
  end
endmodule

// ===== dv/set_assoc_cache_fifo_lru_tb.sv =====
// Self-checking testbench for set_assoc_cache_fifo_lru: a scoreboard class
// predicts hit/miss flags and running totals per access. Depends on sacache_pkg.
module set_assoc_cache_fifo_lru_tb;
  import sacache_pkg::*;

  localparam int LIMIT = 400000;

  class cache_scoreboard;
    bit          line_ok[2048];
    logic [47:0] line_tg[2048];
    logic [63:0] line_age[2048];
    logic [63:0] age_ctr;
    bit   [31:0] hits, misses, reads, writes;
    int          ob, ib, wc;
    bit          lru;
    out_item_t   expected_q[$];
    int          errors;

    function new();
      ob = 6; ib = 4; wc = 1; lru = 0;
      age_ctr = '0; hits = 0; misses = 0; reads = 0; writes = 0; errors = 0;
      foreach (line_ok[i]) line_ok[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        REG_OFFSET_BITS: ob = val;
        REG_INDEX_BITS:  ib = val;
        REG_WAYS:        wc = val;
        REG_USE_LRU:     lru = val[0];
        default: ;
      endcase
    endfunction

    function bit [31:0] bump(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function void note_access(in_item_t it);
      int          eib, ew, set, base, tgt;
      logic [47:0] tag;
      bit          hit, free;
      out_item_t   r;
      eib = (ib > 8) ? 8 : ib;
      ew = (wc == 0) ? 1 : ((wc > 8) ? 8 : wc);
      set = int'((it.address >> ob) & ((48'd1 << eib) - 48'd1));
      tag = it.address >> (ob + eib);
      base = set * 8;
      hit = 0;
      for (int w = 0; w < ew; w++) begin
        if (line_ok[base+w] && line_tg[base+w] == tag) begin
          hit = 1;
          if (lru) begin
            line_age[base+w] = age_ctr;
            age_ctr++;
          end
          break;
        end
      end
      if (!hit) begin
        tgt = 0; free = 0;
        for (int w = 0; w < ew; w++) begin
          if (!line_ok[base+w]) begin
            tgt = w; free = 1;
            break;
          end
        end
        if (!free)
          for (int w = 1; w < ew; w++)
            if (line_age[base+tgt] > line_age[base+w]) tgt = w;
        line_ok[base+tgt] = 1;
        line_tg[base+tgt] = tag;
        line_age[base+tgt] = age_ctr;
        age_ctr++;
        misses = bump(misses);
        reads = bump(reads);
      end else begin
        hits = bump(hits);
      end
      if (it.is_write) writes = bump(writes);
      r.hit = hit;
      r.mem_read = !hit;
      r.mem_write = it.is_write;
      r.hit_total = hits;
      r.miss_total = misses;
      r.read_total = reads;
      r.write_total = writes;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        report("result with no access pending");
        return;
      end
      e = expected_q.pop_front();
      if (got.hit !== e.hit) report($sformatf("hit %0d exp %0d", got.hit, e.hit));
      if (got.mem_read !== e.mem_read)
        report($sformatf("mem_read %0d exp %0d", got.mem_read, e.mem_read));
      if (got.mem_write !== e.mem_write)
        report($sformatf("mem_write %0d exp %0d", got.mem_write, e.mem_write));
      if (got.hit_total !== e.hit_total)
        report($sformatf("hit_total %0d exp %0d", got.hit_total, e.hit_total));
      if (got.miss_total !== e.miss_total)
        report($sformatf("miss_total %0d exp %0d", got.miss_total, e.miss_total));
      if (got.read_total !== e.read_total)
        report($sformatf("read_total %0d exp %0d", got.read_total, e.read_total));
      if (got.write_total !== e.write_total)
        report($sformatf("write_total %0d exp %0d", got.write_total, e.write_total));
    endtask
  endclass

  logic        clk = 0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  cache_scoreboard sb = new();
  int  cycles = 0;
  bit  calm = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  logic [47:0] addr_pool[16];

  set_assoc_cache_fifo_lru dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_access(in_item);
  end

  // result side: random stalls plus one long hold on request
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
    if (hold_req) begin
      hold_req = 0;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 21);
    end
  end

  task send(logic wr, logic [47:0] a);
    in_item_t it;
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    it.is_write = wr;
    it.address = a;
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task configure(int o, int i, int w, int l);
    drain();
    write_reg(REG_OFFSET_BITS, 4'(o));
    write_reg(REG_INDEX_BITS, 4'(i));
    write_reg(REG_WAYS, 4'(w));
    write_reg(REG_USE_LRU, 4'(l));
  endtask

  function logic [47:0] rand_addr();
    return 48'({$urandom, $urandom});
  endfunction

  task run_phase(int n);
    foreach (addr_pool[k]) addr_pool[k] = rand_addr();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 75)
        send(1'($urandom_range(1)), addr_pool[$urandom_range(15)] ^ 48'($urandom_range(3)));
      else
        send(1'($urandom_range(1)), rand_addr());
    end
  endtask

  initial begin
    rst <= 1;
    in_valid <= 0;
    in_item <= '0;
    cfg_we <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed, reset config: extremes, hit after miss, single-way conflict
    send(0, 48'h0);
    send(1, 48'h0);
    send(0, 48'hFFFF_FFFF_FFFF);
    send(1, 48'hFFFF_FFFF_FFFF);
    send(0, 48'h40);
    send(1, 48'h1_0000);
    send(0, 48'h0);
    send(0, 48'h1_0000);
    send(1, 48'hAAAA_AAAA_AAAA);
    send(0, 48'h5555_5555_5555);
    // oversized fields: index clamps to 8, ways clamp to 8
    configure(15, 15, 15, 1);
    for (int k = 0; k < 10; k++) send(k[0], {35'(k % 3), 13'h0});
    // zero ways acts as one, zero offset and index
    configure(0, 0, 0, 0);
    send(1, 48'h1);
    send(0, 48'h1);
    send(0, 48'h2);

    configure(6, 4, 1, 0);
    run_phase(120);
    configure(12, 8, 8, 1);
    run_phase(60);
    hold_req = 1;
    run_phase(80);
    configure(4, 2, 4, 0);
    calm = 1;
    run_phase(150);
    calm = 0;
    configure(3, 3, 2, 1);
    run_phase(70);
    drain();
    run_phase(70);
    configure(0, 0, 8, 0);
    run_phase(120);
    configure(5, 1, 3, 1);
    run_phase(120);
    configure(12, 8, 1, 1);
    run_phase(60);
    configure(2, 9, 16 - 1, 0);
    run_phase(100);

    drain();
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.report("results still outstanding");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
